FILE: sv/stb_pkg.sv
// Shared types, codes and constants of the slot table request batcher.
`default_nettype none
package stb_pkg;

  localparam int STB_SLOTS    = 256;
  localparam int STB_TAG_BITS = 16;
  localparam int BATCH_MAX    = 64;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  localparam logic [1:0] CFG_BATCH_LIMIT = 2'd0;
  localparam logic [1:0] CFG_TIME_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_MAX_SCAN    = 2'd2;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_FULL   = 3'd1,
    ST_ENTRY  = 3'd2,
    ST_NONE   = 3'd3,
    ST_BUSY   = 3'd4
  } status_t;

  typedef struct packed {
    logic        cmd;
    logic [63:0] req_key;
    logic [63:0] row_id;
    logic [15:0] request_tag;
    logic [63:0] now_us;
    logic        ring_ready;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slot_no;
    logic [63:0] out_row_id;
    logic [15:0] out_tag;
    logic [63:0] batch_number;
    logic [6:0]  batch_size;
    logic        last;
  } out_word_t;

endpackage
`default_nettype wire

FILE: sv/slot_table_request_batcher.sv
// Slot table request batcher: parks requests in slots and releases batches.
// Submit: the key is hashed, then slots are probed one by one from the hashed slot;
//   drain: an age pass over the whole table (only below the batch limit), the claim
//   pass and the release pass, each a read and a check per slot; output stalls hold it.
// Items: one at a time; in_stall is high outside S_IDLE. The single-port slot RAM
//   is read by the sequencer through a read state and a check state per slot.
// Reset: synchronous; afterwards the table is cleared one slot per cycle
//   while in_stall stays high.
`default_nettype none
module slot_table_request_batcher
  import stb_pkg::*;
#(
  parameter int SLOTS    = STB_SLOTS,
  parameter int TAG_BITS = STB_TAG_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [23:0] cfg_wdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = 1 + 64 + 64 + TAG_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CHK, S_AGE_RD, S_AGE_CHK,
    S_AGE_EVAL, S_SCAN_RD, S_SCAN_CHK, S_SCAN_END, S_EMIT_RD, S_EMIT_CHK, S_REPLY
  } state_t;

  state_t        state_r;
  in_word_t      item_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] start_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] found_r;
  logic [CW-1:0] emitted_r;
  logic [CW-1:0] pend_total_r;
  logic [IW-1:0] scan_start_r;
  logic [63:0]   batch_cnt_r;
  logic [63:0]   oldest_r;
  logic          old_found_r;
  status_t       reply_st_r;
  logic [IW-1:0] reply_slot_r;
  logic          out_valid_r;
  out_word_t     out_r;
  logic [6:0]    batch_limit_r;
  logic [23:0]   time_limit_r;
  logic [8:0]    max_scan_r;

  // slot RAM port
  logic          ram_we;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;
  logic                ent_pend;
  logic [63:0]         ent_row;
  logic [63:0]         ent_stamp;
  logic [TAG_BITS-1:0] ent_tag;

  logic          mix_start;
  logic          mix_done;
  logic [IW-1:0] mix_slot;

  logic [6:0]    lim;
  logic [CW-1:0] scan_len;
  logic [CW-1:0] claim_max;
  logic [IW-1:0] idx_inc;
  logic [CW:0]   cursor_sum;
  logic [IW-1:0] cursor_nxt;
  logic [CW-1:0] found_nxt;
  logic [31:0]   tag_in_w;
  logic [31:0]   tag_out_w;
  logic [63:0]   age;
  logic          out_free;
  logic          out_load;
  logic          accept;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // load the output register on a reply or a released entry
  assign out_load = out_free &&
                    ((state_r == S_REPLY) || (state_r == S_EMIT_CHK && ent_pend));

  assign {ent_pend, ent_row, ent_stamp, ent_tag} = ram_rdata;

  // clamp the limits
  always_comb begin
    if (batch_limit_r == 7'd0) begin
      lim = 7'd1;
    end else if (batch_limit_r > 7'(BATCH_MAX)) begin
      lim = 7'(BATCH_MAX);
    end else begin
      lim = batch_limit_r;
    end
    if (max_scan_r == 9'd0 || 32'(max_scan_r) > SLOTS) begin
      scan_len = CW'(SLOTS);
    end else begin
      scan_len = CW'(max_scan_r);
    end
    claim_max = (CW'(lim) < scan_len) ? CW'(lim) : scan_len;
  end

  assign idx_inc    = (idx_r == IW'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign cursor_sum = (CW+1)'(start_r) + (CW+1)'(scan_len);
  assign cursor_nxt = (cursor_sum >= (CW+1)'(SLOTS)) ?
                      IW'(cursor_sum - (CW+1)'(SLOTS)) : IW'(cursor_sum);
  assign found_nxt  = found_r + CW'(ent_pend);
  assign tag_in_w   = 32'(item_r.request_tag);
  assign tag_out_w  = 32'(ent_tag);
  assign age        = item_r.now_us - oldest_r;

  // slot RAM writes: clear pass, submit store, release
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {1'b0, ent_row, ent_stamp, ent_tag};
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_PROBE_CHK: begin
        ram_we    = !ent_pend;
        ram_wdata = {1'b1, item_r.row_id, item_r.now_us, tag_in_w[TAG_BITS-1:0]};
      end
      S_EMIT_CHK: begin
        ram_we = ent_pend && out_free;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign mix_start = accept && (in_data.cmd == CMD_SUBMIT);

  stb_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (idx_r),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  stb_mix #(.SLOTS(SLOTS)) u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mix_start),
    .din   (in_data.req_key),
    .done  (mix_done),
    .slot  (mix_slot)
  );

  // hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_limit_r <= 7'd32;
      time_limit_r  <= 24'd100;
      max_scan_r    <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BATCH_LIMIT: batch_limit_r <= cfg_wdata[6:0];
        CFG_TIME_LIMIT:  time_limit_r  <= cfg_wdata;
        CFG_MAX_SCAN:    max_scan_r    <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // sequencer and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      idx_r        <= '0;
      pend_total_r <= '0;
      scan_start_r <= '0;
      batch_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          idx_r <= idx_inc;
          if (idx_r == IW'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_r <= in_data;
            if (in_data.cmd == CMD_SUBMIT) begin
              state_r <= S_HASH;
            end else if (pend_total_r == '0) begin
              reply_st_r   <= ST_NONE;
              reply_slot_r <= '0;
              state_r      <= S_REPLY;
            end else if (pend_total_r < CW'(lim)) begin
              idx_r       <= '0;
              cnt_r       <= '0;
              old_found_r <= 1'b0;
              state_r     <= S_AGE_RD;
            end else begin
              idx_r   <= scan_start_r;
              start_r <= scan_start_r;
              cnt_r   <= '0;
              found_r <= '0;
              state_r <= S_SCAN_RD;
            end
          end
        end
        S_HASH: begin
          if (mix_done) begin
            idx_r   <= mix_slot;
            cnt_r   <= '0;
            state_r <= S_PROBE_RD;
          end
        end
        S_PROBE_RD: state_r <= S_PROBE_CHK;
        S_PROBE_CHK: begin
          if (!ent_pend) begin
            pend_total_r <= pend_total_r + 1'b1;
            reply_st_r   <= ST_ACCEPT;
            reply_slot_r <= idx_r;
            state_r      <= S_REPLY;
          end else if (cnt_r == CW'(SLOTS - 1)) begin
            reply_st_r   <= ST_FULL;
            reply_slot_r <= '0;
            state_r      <= S_REPLY;
          end else begin
            idx_r   <= idx_inc;
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_PROBE_RD;
          end
        end
        S_AGE_RD: state_r <= S_AGE_CHK;
        S_AGE_CHK: begin
          // track the oldest nonzero stamp
          if (ent_pend && ent_stamp != 64'd0 && (!old_found_r || ent_stamp < oldest_r)) begin
            oldest_r    <= ent_stamp;
            old_found_r <= 1'b1;
          end
          if (cnt_r == CW'(SLOTS - 1)) begin
            state_r <= S_AGE_EVAL;
          end else begin
            idx_r   <= idx_inc;
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_AGE_RD;
          end
        end
        S_AGE_EVAL: begin
          if (!old_found_r || item_r.now_us < oldest_r || age < 64'(time_limit_r)) begin
            reply_st_r   <= ST_NONE;
            reply_slot_r <= '0;
            state_r      <= S_REPLY;
          end else begin
            idx_r   <= scan_start_r;
            start_r <= scan_start_r;
            cnt_r   <= '0;
            found_r <= '0;
            state_r <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          // count claimable slots
          found_r <= found_nxt;
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r + 1'b1 == scan_len || found_nxt == claim_max) begin
            state_r <= S_SCAN_END;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_SCAN_RD;
          end
        end
        S_SCAN_END: begin
          scan_start_r <= cursor_nxt;
          reply_slot_r <= '0;
          if (found_r == '0) begin
            reply_st_r <= ST_NONE;
            state_r    <= S_REPLY;
          end else if (!item_r.ring_ready) begin
            reply_st_r <= ST_BUSY;
            state_r    <= S_REPLY;
          end else begin
            batch_cnt_r <= batch_cnt_r + 64'd1;
            emitted_r   <= '0;
            idx_r       <= start_r;
            state_r     <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: state_r <= S_EMIT_CHK;
        S_EMIT_CHK: begin
          // release claimed slots in scan order
          if (ent_pend) begin
            if (out_free) begin
              out_r.status       <= ST_ENTRY;
              out_r.slot_no      <= 8'(idx_r);
              out_r.out_row_id   <= ent_row;
              out_r.out_tag      <= tag_out_w[15:0];
              out_r.batch_number <= batch_cnt_r;
              out_r.batch_size   <= 7'(found_r);
              out_r.last         <= (emitted_r + 1'b1 == found_r);
              pend_total_r       <= pend_total_r - 1'b1;
              emitted_r          <= emitted_r + 1'b1;
              if (emitted_r + 1'b1 == found_r) begin
                state_r <= S_IDLE;
              end else begin
                idx_r   <= idx_inc;
                state_r <= S_EMIT_RD;
              end
            end
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_EMIT_RD;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_r.status       <= reply_st_r;
            out_r.slot_no      <= 8'(reply_slot_r);
            out_r.out_row_id   <= '0;
            out_r.out_tag      <= '0;
            out_r.batch_number <= '0;
            out_r.batch_size   <= '0;
            out_r.last         <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: sv/stb_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module stb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write and read one address per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule
`default_nettype wire

FILE: sv/stb_mix.sv
// 64-bit fmix hash on one shared 32x32 multiplier, then a mask to the slot count.
`default_nettype none
module stb_mix
  import stb_pkg::*;
#(
  parameter int SLOTS = STB_SLOTS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [63:0]              din,
  output logic                          done,
  output logic      [$clog2(SLOTS)-1:0] slot
);

  localparam int IW = $clog2(SLOTS);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_XOR} mstate_t;

  mstate_t       state_r;
  logic [1:0]    phase_r;
  logic          round_r;
  logic [63:0]   x_r;
  logic [63:0]   acc_r;
  logic          done_r;

  logic [63:0] coef;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  // shared multiplier: partial products of the low 64 bits
  assign coef  = round_r ? MIX_C2 : MIX_C1;
  assign ma    = (phase_r == 2'd2) ? x_r[63:32] : x_r[31:0];
  assign mb    = (phase_r == 2'd1) ? coef[63:32] : coef[31:0];
  assign prod  = 64'(ma) * 64'(mb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            x_r     <= din ^ (din >> 33);
            round_r <= 1'b0;
            phase_r <= 2'd0;
            state_r <= M_MUL;
          end
        end
        M_MUL: begin
          if (phase_r == 2'd0) begin
            acc_r <= prod;
          end else begin
            acc_r <= acc_r + {prod[31:0], 32'h0};
          end
          if (phase_r == 2'd2) begin
            state_r <= M_XOR;
          end
          phase_r <= phase_r + 2'd1;
        end
        M_XOR: begin
          x_r     <= acc_r ^ (acc_r >> 33);
          phase_r <= 2'd0;
          if (round_r) begin
            done_r  <= 1'b1;
            state_r <= M_IDLE;
          end else begin
            round_r <= 1'b1;
            state_r <= M_MUL;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  // slot count is a power of two: keep the low bits of the hash
  assign done = done_r;
  assign slot = x_r[IW-1:0];

endmodule
`default_nettype wire

FILE: sv/stb_checker.sv
// Port-level assertions for the slot table request batcher, bound to the top.
`default_nettype none
module stb_checker
  import stb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  // the table clear follows every reset
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // every accepted item stalls the input in the cycle after it is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken in back-to-back cycles");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output word changed");

  // single-result answers always close the item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_ENTRY) |-> out_data.last)
    else $error("non-batch word without last");

  a_entry_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_ENTRY) |->
    (out_data.batch_size != 7'd0 && out_data.batch_number != 64'd0))
    else $error("batch entry with empty size or number");

endmodule

bind slot_table_request_batcher stb_checker u_stb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

FILE: tb/tb_slot_table_request_batcher.sv
// Testbench for the slot table request batcher: directed and random traffic against a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_slot_table_request_batcher
  import stb_pkg::*;
();

  // Scoreboard: mirrors the slot table and holds the expected batch words
  class batch_scoreboard;
    int unsigned batch_lim;
    int unsigned age_lim;
    int unsigned scan_lim;
    bit          busy_slot [STB_SLOTS];
    logic [63:0] row_of [STB_SLOTS];
    logic [63:0] stamp_of [STB_SLOTS];
    logic [15:0] tag_of [STB_SLOTS];
    int unsigned parked;
    int unsigned cursor;
    logic [63:0] batches_sent;
    out_word_t   pending_words[$];
    int          errors;

    function new();
      batch_lim = 32;
      age_lim = 100;
      scan_lim = 0;
      parked = 0;
      cursor = 0;
      batches_sent = '0;
      errors = 0;
      foreach (busy_slot[i]) busy_slot[i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        CFG_BATCH_LIMIT: batch_lim = val[6:0];
        CFG_TIME_LIMIT: age_lim = val;
        CFG_MAX_SCAN: scan_lim = val[8:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] fmix(logic [63:0] x);
      x = x ^ (x >> 33);
      x = x * MIX_C1;
      x = x ^ (x >> 33);
      x = x * MIX_C2;
      x = x ^ (x >> 33);
      return x;
    endfunction

    function void push_word(status_t st, int unsigned slot, logic [63:0] row,
                            logic [15:0] tag, logic [63:0] num, int unsigned sz,
                            bit lst);
      out_word_t w;
      w.status = st;
      w.slot_no = slot[7:0];
      w.out_row_id = row;
      w.out_tag = tag;
      w.batch_number = num;
      w.batch_size = sz[6:0];
      w.last = lst;
      pending_words.push_back(w);
    endfunction

    // Note one accepted input word and queue what it should produce
    function void note_input(in_word_t d);
      int unsigned first, idx, lim, scan, most, cnt;
      int unsigned picked[$];
      logic [63:0] oldest;
      bit found;
      if (d.cmd == CMD_SUBMIT) begin
        first = 32'(fmix(d.req_key) % 64'(STB_SLOTS));
        for (int i = 0; i < STB_SLOTS; i++) begin
          idx = (first + i) % STB_SLOTS;
          if (!busy_slot[idx]) begin
            busy_slot[idx] = 1'b1;
            row_of[idx] = d.row_id;
            tag_of[idx] = d.request_tag;
            stamp_of[idx] = d.now_us;
            parked++;
            push_word(ST_ACCEPT, idx, '0, '0, '0, 0, 1'b1);
            return;
          end
        end
        push_word(ST_FULL, 0, '0, '0, '0, 0, 1'b1);
        return;
      end
      lim = batch_lim;
      if (lim == 0) lim = 1;
      if (lim > BATCH_MAX) lim = BATCH_MAX;
      if (parked == 0) begin
        push_word(ST_NONE, 0, '0, '0, '0, 0, 1'b1);
        return;
      end
      // Below the size trigger, check the age of the oldest nonzero stamp
      if (parked < lim) begin
        found = 1'b0;
        oldest = '0;
        for (int s = 0; s < STB_SLOTS; s++)
          if (busy_slot[s] && stamp_of[s] != 0 && (!found || stamp_of[s] < oldest)) begin
            oldest = stamp_of[s];
            found = 1'b1;
          end
        if (!found || d.now_us < oldest || d.now_us - oldest < 64'(age_lim)) begin
          push_word(ST_NONE, 0, '0, '0, '0, 0, 1'b1);
          return;
        end
      end
      scan = STB_SLOTS;
      if (scan_lim > 0 && scan > scan_lim) scan = scan_lim;
      most = (lim < scan) ? lim : scan;
      for (int s = 0; s < scan && picked.size() < most; s++) begin
        idx = (cursor + s) % STB_SLOTS;
        if (busy_slot[idx]) picked.push_back(idx);
      end
      cursor = (cursor + scan) % STB_SLOTS;
      cnt = picked.size();
      if (cnt == 0) begin
        push_word(ST_NONE, 0, '0, '0, '0, 0, 1'b1);
        return;
      end
      if (!d.ring_ready) begin
        push_word(ST_BUSY, 0, '0, '0, '0, 0, 1'b1);
        return;
      end
      batches_sent++;
      foreach (picked[k]) begin
        idx = picked[k];
        push_word(ST_ENTRY, idx, row_of[idx], tag_of[idx], batches_sent, cnt,
                  k == cnt - 1);
        busy_slot[idx] = 1'b0;
        parked--;
      end
    endfunction

    // Compare one result word with the oldest expectation
    function void check_output(out_word_t got);
      out_word_t exp_w;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, got);
        errors++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.status !== exp_w.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, exp_w.status, got.status);
        errors++;
      end
      if (got.slot_no !== exp_w.slot_no) begin
        $display("%0t: slot exp %0d got %0d", $realtime, exp_w.slot_no, got.slot_no);
        errors++;
      end
      if (got.out_row_id !== exp_w.out_row_id) begin
        $display("%0t: row exp %h got %h", $realtime, exp_w.out_row_id, got.out_row_id);
        errors++;
      end
      if (got.out_tag !== exp_w.out_tag) begin
        $display("%0t: tag exp %h got %h", $realtime, exp_w.out_tag, got.out_tag);
        errors++;
      end
      if (got.batch_number !== exp_w.batch_number) begin
        $display("%0t: batch exp %0d got %0d", $realtime, exp_w.batch_number,
                 got.batch_number);
        errors++;
      end
      if (got.batch_size !== exp_w.batch_size) begin
        $display("%0t: size exp %0d got %0d", $realtime, exp_w.batch_size, got.batch_size);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $display("%0t: last exp %0b got %0b", $realtime, exp_w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  batch_scoreboard board;
  int          quiet_cycles;
  bit          stall_enable;
  logic [63:0] clock_us;

  slot_table_request_batcher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Check results and count quiet cycles at each rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_output(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Random receiver stall, changed on the falling edge
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_enable && $urandom_range(0, 3) == 0) begin
        hold = gap_len();
        out_stall <= 1'b1;
        repeat (hold + 1) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Send one word and hold it until accepted, then drop valid
  task automatic send_word(in_word_t w);
    int g;
    g = gap_len();
    repeat (g + 1) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(w);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every expected word, then let the block settle
  task automatic drain_out();
    while (board.pending_words.size() != 0) @(negedge clk);
    repeat (1500) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  function automatic in_word_t submit_word(logic [63:0] rid, logic [63:0] now);
    in_word_t w;
    w.cmd = CMD_SUBMIT;
    w.req_key = rid;
    w.row_id = {$urandom, $urandom};
    w.request_tag = 16'($urandom);
    w.now_us = now;
    w.ring_ready = 1'($urandom);
    return w;
  endfunction

  function automatic in_word_t drain_word(logic [63:0] now, bit ready);
    in_word_t w;
    w.cmd = CMD_DRAIN;
    w.req_key = {$urandom, $urandom};
    w.row_id = {$urandom, $urandom};
    w.request_tag = 16'($urandom);
    w.now_us = now;
    w.ring_ready = ready;
    return w;
  endfunction

  initial begin
    in_word_t w;
    board = new();
    quiet_cycles = 0;
    stall_enable = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    clock_us = 64'd1000;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty drain, zero stamp, extreme fields, age trigger, busy ring
    send_word(drain_word(64'd0, 1'b1));
    send_word(submit_word(64'd0, 64'd0));
    w = submit_word('1, 64'd500);
    w.row_id = '1;
    w.request_tag = '1;
    send_word(w);
    w = submit_word(64'h5555_5555_5555_5555, '1);
    w.row_id = '0;
    w.request_tag = '0;
    send_word(w);
    send_word(drain_word(64'd550, 1'b1));
    send_word(drain_word(64'd10, 1'b1));
    send_word(drain_word(64'd600, 1'b0));
    send_word(drain_word(64'd600, 1'b1));
    send_word(drain_word('1, 1'b1));
    drain_out();

    // Fill the table past full, then drain it with tight and with wide scan limits
    stall_enable = 1'b1;
    write_reg(CFG_BATCH_LIMIT, 24'd0);
    write_reg(CFG_TIME_LIMIT, 24'hffffff);
    write_reg(CFG_MAX_SCAN, 24'd1);
    write_reg(CFG_BATCH_LIMIT, 24'd64);
    for (int i = 0; i < 258; i++) begin
      send_word(submit_word({$urandom, $urandom}, 64'd0));
      if (i % 64 == 63) drain_out();
    end
    send_word(drain_word(64'd1, 1'b1));
    drain_out();
    write_reg(CFG_MAX_SCAN, 24'd256);
    write_reg(CFG_BATCH_LIMIT, 24'd127);
    for (int i = 0; i < 6; i++) send_word(drain_word(64'd5, $urandom_range(0, 3) != 0));
    drain_out();

    // Random phases with different settings
    for (int ph = 0; ph < 2; ph++) begin
      write_reg(CFG_BATCH_LIMIT,
                $urandom_range(0, 3) == 0 ? 24'd64 : 24'($urandom_range(1, 12)));
      write_reg(CFG_TIME_LIMIT,
                $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(1, 200)));
      write_reg(CFG_MAX_SCAN, ph == 1 ? 24'd511 : 24'($urandom_range(0, 40)));
      for (int i = 0; i < 70; i++) begin
        clock_us = clock_us + $urandom_range(0, 60);
        if ($urandom_range(0, 9) < 6)
          send_word(submit_word({$urandom, $urandom},
                                $urandom_range(0, 15) == 0 ? 64'd0 : clock_us));
        else
          send_word(drain_word($urandom_range(0, 15) == 0 ? {$urandom, $urandom} : clock_us,
                               $urandom_range(0, 4) != 0));
      end
      drain_out();
    end

    // Empty the table so the run ends quietly
    write_reg(CFG_BATCH_LIMIT, 24'd64);
    write_reg(CFG_MAX_SCAN, 24'd0);
    for (int i = 0; i < 5; i++) send_word(drain_word(clock_us, 1'b1));
    drain_out();

    if (board.errors == 0 && board.pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
sv/stb_pkg.sv
sv/stb_ram.sv
sv/stb_mix.sv
sv/slot_table_request_batcher.sv
sv/stb_checker.sv
tb/tb_slot_table_request_batcher.sv
